// ===== rtl/spp_pkg.sv =====
// Shared types, constants and the frequency table of the speed to pulse prescaler.
`default_nettype none

package spp_pkg;

  // Input and output field widths.
  localparam int SPEED_W = 12;
  localparam int KMH_W   = 8;
  localparam int NUM_W   = 18;
  localparam int HZ_W    = 8;
  localparam int PRE_W   = 16;
  localparam int DHZ_W   = 11;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_ADDR_W-1:0] REG_NUMERATOR = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED = 1'd1;
  localparam logic [NUM_W-1:0] NUMERATOR_RST = 18'd200000;
  localparam logic [KMH_W-1:0] MIN_SPEED_RST = 8'd5;

  // Divider sizing: the dividend covers both the interpolation sum and the numerator.
  localparam int DIV_DW    = 20;
  localparam int DIV_VW    = 12;
  localparam int DIV_CNT_W = $clog2(DIV_DW + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_DW);

  // Table frequencies are stored in tenths of Hz.
  localparam logic [DIV_VW-1:0] DHZ_PER_HZ = 12'd10;

  // Interpolation table of (km/h, tenths of Hz) points.
  localparam int TBL_ENTRIES = 23;
  localparam int IDX_W       = $clog2(TBL_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_ENTRIES - 1);

  localparam logic [KMH_W-1:0] TBL_KMH [0:TBL_ENTRIES-1] = '{
    8'd5,   8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,
    8'd80,  8'd90,  8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150,
    8'd160, 8'd170, 8'd180, 8'd190, 8'd200, 8'd210, 8'd220
  };

  localparam logic [DHZ_W-1:0] TBL_DHZ [0:TBL_ENTRIES-1] = '{
    11'd35,   11'd75,   11'd148,  11'd225,  11'd302,  11'd380,
    11'd457,  11'd530,  11'd610,  11'd690,  11'd770,  11'd850,
    11'd935,  11'd1020, 11'd1100, 11'd1185, 11'd1280, 11'd1370,
    11'd1460, 11'd1550, 11'd1640, 11'd1730, 11'd1820
  };

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_MUL1,
    ST_MUL2,
    ST_LUT_START,
    ST_LUT_WAIT,
    ST_PRE_START,
    ST_PRE_WAIT,
    ST_FINISH
  } state_t;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/spp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module spp_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire spp_pkg::div_ctl_t            ctl,
  input  wire logic [spp_pkg::DIV_DW-1:0]   dividend,
  input  wire logic [spp_pkg::DIV_VW-1:0]   divisor,
  output spp_pkg::div_sts_t                 sts,
  output logic      [spp_pkg::DIV_DW-1:0]   quotient
);

  logic                          busy;
  logic                          done;
  logic [spp_pkg::DIV_CNT_W-1:0] cnt;
  logic [spp_pkg::DIV_DW-1:0]    quo;
  logic [spp_pkg::DIV_VW-1:0]    rem;
  logic [spp_pkg::DIV_VW-1:0]    dsr;

  logic [spp_pkg::DIV_VW:0]      trial;
  logic                          qbit;
  logic [spp_pkg::DIV_VW-1:0]    rem_next;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem, quo[spp_pkg::DIV_DW-1]};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? spp_pkg::DIV_VW'(trial - {1'b0, dsr})
                    : trial[spp_pkg::DIV_VW-1:0];
  end

  // Step counter and status flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= spp_pkg::DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == spp_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[spp_pkg::DIV_DW-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/speed_to_pulse_prescaler_unit.sv =====
// Top level: config registers, table search, interpolation and output register.
// A speed at or below the threshold skips to the output register; any other speed goes
// through a table search of up to 22 steps and two multiply steps (both skipped for a
// speed clamped at a table end) and two 20-step divisions sharing one restoring divider.
// A stalled result holds off the next item, which is taken only after it is loaded.
// Reset is synchronous: registers return to 200000 and 5, and the output is empty.
`default_nettype none

module speed_to_pulse_prescaler_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream; s_tdata: speed_q4 [11:0], zero padding above.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [spp_pkg::S_DATA_W-1:0]     s_tdata,
  // Result stream; m_tdata: timer_enable [0], frequency_hz [8:1], prescaler [24:9].
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [spp_pkg::M_DATA_W-1:0]     m_tdata,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [spp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [spp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spp_pkg::state_t state, state_next;

  logic [spp_pkg::NUM_W-1:0]   numerator;
  logic [spp_pkg::KMH_W-1:0]   min_speed_kmh;

  logic [spp_pkg::SPEED_W-1:0] speed;
  logic                        en;
  logic [spp_pkg::IDX_W-1:0]   idx;
  logic [spp_pkg::KMH_W-1:0]   dv;
  logic [spp_pkg::DHZ_W-1:0]   df;
  logic [spp_pkg::DHZ_W-1:0]   f0;
  logic [spp_pkg::KMH_W-1:0]   dk;
  logic [spp_pkg::KMH_W+spp_pkg::DHZ_W-1:0] prod;
  logic [spp_pkg::DIV_DW-1:0]  inum;
  logic [spp_pkg::DIV_VW-1:0]  idiv;
  logic [spp_pkg::HZ_W-1:0]    hz;
  logic [spp_pkg::PRE_W-1:0]   presc;

  logic                        out_en;
  logic [spp_pkg::HZ_W-1:0]    out_hz;
  logic [spp_pkg::PRE_W-1:0]   out_presc;

  logic [spp_pkg::KMH_W-1:0]   v;
  logic                        enable_w;
  logic                        clamp_lo;
  logic                        clamp_hi;
  logic                        found;
  logic                        out_load;

  spp_pkg::div_ctl_t           div_ctl;
  spp_pkg::div_sts_t           div_sts;
  logic [spp_pkg::DIV_DW-1:0]  div_dividend;
  logic [spp_pkg::DIV_VW-1:0]  div_divisor;
  logic [spp_pkg::DIV_DW-1:0]  div_quo;

  // Whole km/h value and the threshold and clamp tests.
  assign v        = speed[spp_pkg::SPEED_W-1:4];
  assign enable_w = (speed > {min_speed_kmh, 4'b0000});
  assign clamp_lo = (v <= spp_pkg::TBL_KMH[0]);
  assign clamp_hi = (v >= spp_pkg::TBL_KMH[spp_pkg::LAST_IDX]);
  assign found    = (v <= spp_pkg::TBL_KMH[idx]);
  assign out_load = (state == spp_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      numerator     <= spp_pkg::NUMERATOR_RST;
      min_speed_kmh <= spp_pkg::MIN_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        spp_pkg::REG_NUMERATOR: numerator     <= cfg_data;
        spp_pkg::REG_MIN_SPEED: min_speed_kmh <= cfg_data[spp_pkg::KMH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and divider operand selection.
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    div_ctl.start = 1'b0;
    div_dividend  = inum;
    div_divisor   = idiv;
    case (state)
      spp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = spp_pkg::ST_CHECK;
      end
      spp_pkg::ST_CHECK: begin
        if (!enable_w) state_next = spp_pkg::ST_FINISH;
        else if (clamp_lo || clamp_hi) state_next = spp_pkg::ST_LUT_START;
        else state_next = spp_pkg::ST_SEARCH;
      end
      spp_pkg::ST_SEARCH: begin
        if (found) state_next = spp_pkg::ST_MUL1;
      end
      spp_pkg::ST_MUL1: state_next = spp_pkg::ST_MUL2;
      spp_pkg::ST_MUL2: state_next = spp_pkg::ST_LUT_START;
      spp_pkg::ST_LUT_START: begin
        div_ctl.start = 1'b1;
        state_next    = spp_pkg::ST_LUT_WAIT;
      end
      spp_pkg::ST_LUT_WAIT: begin
        if (div_sts.done) state_next = spp_pkg::ST_PRE_START;
      end
      spp_pkg::ST_PRE_START: begin
        div_ctl.start = 1'b1;
        div_dividend  = spp_pkg::DIV_DW'(numerator);
        div_divisor   = spp_pkg::DIV_VW'(hz);
        state_next    = spp_pkg::ST_PRE_WAIT;
      end
      spp_pkg::ST_PRE_WAIT: begin
        if (div_sts.done) state_next = spp_pkg::ST_FINISH;
      end
      spp_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = spp_pkg::ST_IDLE;
      end
      default: state_next = spp_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers, advanced step by step by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      spp_pkg::ST_IDLE: begin
        if (s_tvalid) speed <= s_tdata[spp_pkg::SPEED_W-1:0];
      end
      spp_pkg::ST_CHECK: begin
        en  <= enable_w;
        idx <= spp_pkg::IDX_W'(1);
        if (!enable_w) begin
          hz    <= '0;
          presc <= '0;
        end else if (clamp_lo) begin
          inum <= spp_pkg::DIV_DW'(spp_pkg::TBL_DHZ[0]);
          idiv <= spp_pkg::DHZ_PER_HZ;
        end else begin
          inum <= spp_pkg::DIV_DW'(spp_pkg::TBL_DHZ[spp_pkg::LAST_IDX]);
          idiv <= spp_pkg::DHZ_PER_HZ;
        end
      end
      spp_pkg::ST_SEARCH: begin
        if (found) begin
          // Equal neighboring points collapse to the upper point's value.
          if (spp_pkg::TBL_KMH[idx] == spp_pkg::TBL_KMH[idx - 1'b1]) begin
            dv <= '0;
            df <= '0;
            f0 <= spp_pkg::TBL_DHZ[idx];
            dk <= spp_pkg::KMH_W'(1);
          end else begin
            dv <= v - spp_pkg::TBL_KMH[idx - 1'b1];
            df <= spp_pkg::TBL_DHZ[idx] - spp_pkg::TBL_DHZ[idx - 1'b1];
            f0 <= spp_pkg::TBL_DHZ[idx - 1'b1];
            dk <= spp_pkg::TBL_KMH[idx] - spp_pkg::TBL_KMH[idx - 1'b1];
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
      spp_pkg::ST_MUL1: begin
        prod <= dv * df;
        idiv <= (spp_pkg::DIV_VW'(dk) << 3) + (spp_pkg::DIV_VW'(dk) << 1);
      end
      spp_pkg::ST_MUL2: begin
        inum <= spp_pkg::DIV_DW'(prod)
              + spp_pkg::DIV_DW'(spp_pkg::DIV_DW'(f0) * spp_pkg::DIV_DW'(dk));
      end
      spp_pkg::ST_LUT_WAIT: begin
        if (div_sts.done) hz <= div_quo[spp_pkg::HZ_W-1:0];
      end
      spp_pkg::ST_PRE_WAIT: begin
        // Quotients beyond 16 bits saturate.
        if (div_sts.done) begin
          if (div_quo[spp_pkg::DIV_DW-1:spp_pkg::PRE_W] != '0) presc <= '1;
          else presc <= div_quo[spp_pkg::PRE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_en    <= en;
      out_hz    <= hz;
      out_presc <= presc;
    end
  end

  assign m_tdata = {7'd0, out_presc, out_hz, out_en};

  // Shared divider.
  spp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

`ifndef SYNTHESIS
  // A disabled result carries zero frequency and zero prescaler.
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[24:1] == '0))
    else $error("disabled result has nonzero fields");

  // An enabled result never has a zero frequency with this table.
  a_enabled_hz: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] != '0))
    else $error("enabled result has zero frequency");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == spp_pkg::ST_LUT_WAIT || state == spp_pkg::ST_PRE_WAIT))
    else $error("divider done outside a wait state");

  // A new division never starts while the divider is still running.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  // The table search stays inside the table.
  a_search_idx: assert property (@(posedge clk) disable iff (rst)
    (state == spp_pkg::ST_SEARCH) |-> (idx <= spp_pkg::LAST_IDX && idx != '0))
    else $error("table search index out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the speed to pulse prescaler, with its own table interpolation model.
`default_nettype none

module tb;

  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int REPORT_LIMIT    = 10;
  localparam int NUM_MASK        = 'h3FFFF;
  localparam int KMH_MASK        = 'hFF;
  localparam int PRE_MAX         = 65535;

  // One result: what the pulse timer should be set to.
  typedef struct packed {
    logic                      enable;
    logic [spp_pkg::HZ_W-1:0]  hz;
    logic [spp_pkg::PRE_W-1:0] prescale;
  } pulse_setting_t;

  // Ready patterns of the result receiver.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_pattern_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // s_tdata: speed_q4 [11:0], zero padding above.
  logic [spp_pkg::S_DATA_W-1:0]   s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  // m_tdata: timer_enable [0], frequency_hz [8:1], prescaler [24:9].
  logic [spp_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           cfg_we;
  logic [spp_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [spp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Speedometer calibration points: km/h and tenths of Hz.
  int kmh_pts [0:22] = '{5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100, 110,
                         120, 130, 140, 150, 160, 170, 180, 190, 200, 210, 220};
  int dhz_pts [0:22] = '{35, 75, 148, 225, 302, 380, 457, 530, 610, 690, 770, 850,
                         935, 1020, 1100, 1185, 1280, 1370, 1460, 1550, 1640, 1730,
                         1820};

  // Shadow copies of the configuration registers.
  int num_reg;
  int min_kmh_reg;

  pulse_setting_t pending_settings[$];
  int             fail_count;
  int             cycle_count;
  int             burst_left;

  speed_to_pulse_prescaler_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Interpolated frequency in whole Hz for a whole km/h value, clamped at the ends.
  function automatic int hz_for_kmh(input int kmh);
    int i;
    int dk;
    if (kmh <= kmh_pts[0]) return dhz_pts[0] / 10;
    if (kmh >= kmh_pts[22]) return dhz_pts[22] / 10;
    for (i = 1; i < 23; i++) begin
      if (kmh <= kmh_pts[i]) begin
        dk = kmh_pts[i] - kmh_pts[i-1];
        return ((kmh - kmh_pts[i-1]) * (dhz_pts[i] - dhz_pts[i-1]) + dhz_pts[i-1] * dk)
               / (10 * dk);
      end
    end
    return dhz_pts[22] / 10;
  endfunction

  // Timer setting for one speed under the current register values.
  function automatic pulse_setting_t pulse_setting_for(
    input logic [spp_pkg::SPEED_W-1:0] speed);
    pulse_setting_t r;
    int hz;
    int q;
    r = '0;
    if (int'(speed) <= min_kmh_reg * 16) return r;
    hz = hz_for_kmh(int'(speed) >> 4);
    if (hz == 0) begin
      q = PRE_MAX;
    end else begin
      q = num_reg / hz;
      if (q > PRE_MAX) q = PRE_MAX;
    end
    r.enable   = 1'b1;
    r.hz       = hz[spp_pkg::HZ_W-1:0];
    r.prescale = q[spp_pkg::PRE_W-1:0];
    return r;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", what);
  endtask

  // Send one speed reading; the sender works in bursts with random gaps between them.
  task automatic send_speed(input logic [spp_pkg::SPEED_W-1:0] speed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata  = spp_pkg::S_DATA_W'(speed);
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_settings.push_back(pulse_setting_for(speed));
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
  endtask

  // Register write, issued only once the block has gone idle.
  task automatic set_register(input logic [spp_pkg::CFG_ADDR_W-1:0] addr, input int value);
    wait_for_results();
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = spp_pkg::CFG_DATA_W'(value);
    case (addr)
      spp_pkg::REG_NUMERATOR: num_reg = value & NUM_MASK;
      spp_pkg::REG_MIN_SPEED: min_kmh_reg = value & KMH_MASK;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Values after reset: threshold edge, overflow of 200000 / 3, top speed.
  task automatic test_reset_values();
    send_speed(12'd0);
    send_speed(12'd80);
    send_speed(12'd81);
    send_speed(12'd104);
    send_speed(12'd4095);
  endtask

  // Zero threshold and the largest numerator: below the first point, on points,
  // between points and above the last point.
  task automatic test_table_ends();
    set_register(spp_pkg::REG_MIN_SPEED, 0);
    set_register(spp_pkg::REG_NUMERATOR, NUM_MASK);
    send_speed(12'd0);
    send_speed(12'd1);
    send_speed(12'd79);
    send_speed(12'd160);
    send_speed(12'd250);
    send_speed(12'd3519);
    send_speed(12'd3520);
    send_speed(12'd3840);
  endtask

  // A zero numerator gives a zero prescaler while the timer stays enabled.
  task automatic test_zero_numerator();
    set_register(spp_pkg::REG_NUMERATOR, 0);
    send_speed(12'd2000);
    send_speed(12'd17);
  endtask

  // Highest threshold: only the last few speeds pass it.
  task automatic test_top_threshold();
    set_register(spp_pkg::REG_MIN_SPEED, KMH_MASK);
    set_register(spp_pkg::REG_NUMERATOR, 1);
    send_speed(12'd4080);
    send_speed(12'd4081);
    send_speed(12'd4095);
  endtask

  // Random speeds under a series of register settings, biased toward the
  // threshold and the calibration points.
  task automatic test_random_traffic();
    int phase;
    int n;
    int s;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: set_register(spp_pkg::REG_NUMERATOR, 1);
        1: set_register(spp_pkg::REG_NUMERATOR, NUM_MASK);
        2: set_register(spp_pkg::REG_NUMERATOR, 200000);
        3: set_register(spp_pkg::REG_NUMERATOR, $urandom_range(0, 2000));
        default: set_register(spp_pkg::REG_NUMERATOR, $urandom_range(0, NUM_MASK));
      endcase
      case ($urandom_range(0, 4))
        0: set_register(spp_pkg::REG_MIN_SPEED, 0);
        1: set_register(spp_pkg::REG_MIN_SPEED, KMH_MASK);
        2: set_register(spp_pkg::REG_MIN_SPEED, $urandom_range(0, 20));
        default: set_register(spp_pkg::REG_MIN_SPEED, $urandom_range(0, 60));
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          6, 7: s = min_kmh_reg * 16 + $urandom_range(0, 6) - 3;
          8, 9: s = kmh_pts[$urandom_range(0, 22)] * 16 + $urandom_range(0, 32) - 16;
          default: s = $urandom_range(0, 4095);
        endcase
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        if ($urandom_range(0, 59) == 0) wait_for_results();
        send_speed(s[spp_pkg::SPEED_W-1:0]);
      end
    end
  endtask

  // Result receiver: ready follows a pattern that is picked anew at random after each run.
  initial begin
    rx_pattern_t pattern;
    int run;
    int i;
    m_tready = 1'b0;
    forever begin
      pattern = rx_pattern_t'($urandom_range(0, 3));
      run = $urandom_range(10, 60);
      for (i = 0; i < run; i++) begin
        @(negedge clk);
        case (pattern)
          RX_OPEN:   m_tready = 1'b1;
          RX_COIN:   m_tready = ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
          default:   m_tready = ((i % 20) >= 15);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expected setting.
  always @(posedge clk) begin : check_results
    pulse_setting_t got;
    pulse_setting_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.enable   = m_tdata[0];
      got.hz       = m_tdata[8:1];
      got.prescale = m_tdata[24:9];
      if (pending_settings.size() == 0) begin
        report_failure($sformatf("unexpected result: enable %0d hz %0d prescaler %0d",
                                 got.enable, got.hz, got.prescale));
      end else begin
        want = pending_settings.pop_front();
        if (got.enable !== want.enable || got.hz !== want.hz ||
            got.prescale !== want.prescale) begin
          report_failure($sformatf(
            "mismatch: expected enable %0d hz %0d prescaler %0d, got %0d %0d %0d",
            want.enable, want.hz, want.prescale, got.enable, got.hz, got.prescale));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    num_reg     = 200000;
    min_kmh_reg = 5;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    cfg_we   = 1'b0;
    cfg_addr = spp_pkg::REG_NUMERATOR;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_table_ends();
    test_zero_numerator();
    test_top_threshold();
    test_random_traffic();

    // Drain, then watch a while longer for stray results.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
